### rtl/core/sces_pkg.sv
package sces_pkg;

   // Width of the group-order side of the signer
   localparam int GROUP_BITS = 16;
   localparam int FIELD_BITS_DEF = 16;

   // Register reset values
   localparam logic [GROUP_BITS-1:0] FIELD_PRIME_RST = 16'd11;
   localparam logic [GROUP_BITS-1:0] CURVE_A_RST     = 16'd1;
   localparam logic [GROUP_BITS-1:0] GROUP_ORDER_RST = 16'd13;
   localparam logic [GROUP_BITS-1:0] PRIVATE_KEY_RST = 16'd0;

   typedef enum logic [1:0] {
      CSR_FIELD_PRIME = 2'd0,
      CSR_CURVE_A     = 2'd1,
      CSR_GROUP_ORDER = 2'd2,
      CSR_PRIVATE_KEY = 2'd3
   } csr_idx_type;

   typedef enum logic {
      ALU_DIV = 1'b0,
      ALU_MUL = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RED_X,
      S_RED_Y,
      S_RED_A,
      S_LOOP,
      S_DBL_SQ,
      S_DBL_N1,
      S_DBL_N2,
      S_DBL_N3,
      S_INV_CHK,
      S_INV_DIV,
      S_INV_MUL,
      S_ADD_LAM,
      S_ADD_X1,
      S_ADD_X2,
      S_ADD_X3,
      S_ADD_Y1,
      S_ADD_Y2,
      S_R_MOD,
      S_K_MOD,
      S_KINV_RET,
      S_H_STEP,
      S_H_MUL,
      S_H_SQR,
      S_KEY_MOD,
      S_KEY_MUL,
      S_S_SUM,
      S_S_MUL
   } state_type;

endpackage

### rtl/core/small_curve_ecdsa_signer.sv
// Every modular multiply, every reduction and every Euclid division runs in the single shared
// bit-serial unit, which sets the rate.
// Throughput: one request at a time; a new request is taken once busy drops.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (synchronous, active high) returns to idle and loads p=11, a=1, q=13, key=0.
module small_curve_ecdsa_signer import sces_pkg::*; #(
   parameter int FIELD_BITS = FIELD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_BITS-1:0] req_base_x,
   input  logic [FIELD_BITS-1:0] req_base_y,
   input  logic [GROUP_BITS-1:0] req_message,
   input  logic [GROUP_BITS-1:0] req_nonce,
   output logic                  rsp_valid,
   output logic [GROUP_BITS-1:0] rsp_sig_r,
   output logic [GROUP_BITS-1:0] rsp_sig_s,
   output logic                  rsp_retry_needed,
   input  logic                  csr_we,
   input  csr_idx_type           csr_index,
   input  logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] csr_wdata
);

   localparam int DW = (FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS;

   logic [FIELD_BITS-1:0] prime_ff, prime_in, ca_ff, ca_in;
   logic [GROUP_BITS-1:0] order_ff, order_in, key_ff, key_in;

   alu_ctl_type   alu_ctl;
   logic [DW-1:0] alu_a, alu_b, alu_m, alu_res, alu_quo;
   logic          alu_done;

   // Register file writes
   always_comb begin
      prime_in = prime_ff;
      ca_in    = ca_ff;
      order_in = order_ff;
      key_in   = key_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIELD_PRIME: prime_in = csr_wdata[FIELD_BITS-1:0];
            CSR_CURVE_A:     ca_in    = csr_wdata[FIELD_BITS-1:0];
            CSR_GROUP_ORDER: order_in = csr_wdata[GROUP_BITS-1:0];
            CSR_PRIVATE_KEY: key_in   = csr_wdata[GROUP_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= FIELD_BITS'(FIELD_PRIME_RST);
         ca_ff    <= FIELD_BITS'(CURVE_A_RST);
         order_ff <= GROUP_ORDER_RST;
         key_ff   <= PRIVATE_KEY_RST;
      end else begin
         prime_ff <= prime_in;
         ca_ff    <= ca_in;
         order_ff <= order_in;
         key_ff   <= key_in;
      end
   end

   sces_seq #(.FIELD_BITS(FIELD_BITS)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .base_x           (req_base_x),
      .base_y           (req_base_y),
      .message          (req_message),
      .nonce            (req_nonce),
      .field_prime      (prime_ff),
      .curve_a          (ca_ff),
      .group_order      (order_ff),
      .private_key      (key_ff),
      .alu_ctl          (alu_ctl),
      .alu_a            (alu_a),
      .alu_b            (alu_b),
      .alu_m            (alu_m),
      .alu_done         (alu_done),
      .alu_res          (alu_res),
      .alu_quo          (alu_quo),
      .rsp_valid        (rsp_valid),
      .rsp_sig_r        (rsp_sig_r),
      .rsp_sig_s        (rsp_sig_s),
      .rsp_retry_needed (rsp_retry_needed)
   );

   sces_alu #(.FIELD_BITS(FIELD_BITS)) u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .opa   (alu_a),
      .opb   (alu_b),
      .opm   (alu_m),
      .done  (alu_done),
      .res   (alu_res),
      .quo   (alu_quo)
   );

`ifndef SYNTHESIS
   // A result only appears as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");

   // An accepted request always starts work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request accepted but not busy");

   // One result per request: the strobe is never held or repeated
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe repeated");
`endif

endmodule

### rtl/core/sces_alu.sv
module sces_alu import sces_pkg::*; #(
   parameter int FIELD_BITS = FIELD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  alu_ctl_type             ctl,
   input  logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] opa,
   input  logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] opb,
   input  logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] opm,
   output logic                    done,
   output logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] res,
   output logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] quo
);

   localparam int DW = (FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS;
   localparam int CW = $clog2(DW);

   alu_op_type    op_ff, op_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] sh_ff, sh_in;
   logic [DW-1:0] a_ff, a_in;
   logic [DW-1:0] m_ff, m_in;

   logic [DW:0]   rem_w;
   logic [DW:0]   dbl_w;
   logic [DW:0]   sum_w;
   logic [DW-1:0] dbl_r;

   // One quotient bit or one multiplier bit per cycle, MSB first
   always_comb begin
      op_in   = op_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      rem_w   = {acc_ff, sh_ff[DW-1]};
      dbl_w   = {acc_ff, 1'b0};
      dbl_r   = (dbl_w >= {1'b0, m_ff}) ? DW'(dbl_w - {1'b0, m_ff}) : dbl_w[DW-1:0];
      sum_w   = {1'b0, dbl_r} + (sh_ff[DW-1] ? {1'b0, a_ff} : '0);
      if (ctl.start) begin
         op_in  = ctl.op;
         run_in = 1'b1;
         cnt_in = CW'(DW - 1);
         acc_in = '0;
         sh_in  = (ctl.op == ALU_DIV) ? opa : opb;
         a_in   = opa;
         m_in   = opm;
      end else if (run_ff) begin
         unique case (op_ff)
            ALU_DIV: begin
               if (rem_w >= {1'b0, m_ff}) begin
                  acc_in = DW'(rem_w - {1'b0, m_ff});
                  sh_in  = {sh_ff[DW-2:0], 1'b1};
               end else begin
                  acc_in = rem_w[DW-1:0];
                  sh_in  = {sh_ff[DW-2:0], 1'b0};
               end
            end
            ALU_MUL: begin
               acc_in = (sum_w >= {1'b0, m_ff}) ? DW'(sum_w - {1'b0, m_ff})
                                                 : sum_w[DW-1:0];
               sh_in  = {sh_ff[DW-2:0], 1'b0};
            end
         endcase
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_DIV;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
   end

   assign done = done_ff;
   assign res  = acc_ff;
   assign quo  = sh_ff;

endmodule

### rtl/core/sces_seq.sv
module sces_seq import sces_pkg::*; #(
   parameter int FIELD_BITS = FIELD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_BITS-1:0] base_x,
   input  logic [FIELD_BITS-1:0] base_y,
   input  logic [GROUP_BITS-1:0] message,
   input  logic [GROUP_BITS-1:0] nonce,
   input  logic [FIELD_BITS-1:0] field_prime,
   input  logic [FIELD_BITS-1:0] curve_a,
   input  logic [GROUP_BITS-1:0] group_order,
   input  logic [GROUP_BITS-1:0] private_key,
   output alu_ctl_type           alu_ctl,
   output logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] alu_a,
   output logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] alu_b,
   output logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] alu_m,
   input  logic                  alu_done,
   input  logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] alu_res,
   input  logic [((FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS)-1:0] alu_quo,
   output logic                  rsp_valid,
   output logic [GROUP_BITS-1:0] rsp_sig_r,
   output logic [GROUP_BITS-1:0] rsp_sig_s,
   output logic                  rsp_retry_needed
);

   localparam int DW = (FIELD_BITS > GROUP_BITS) ? FIELD_BITS : GROUP_BITS;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [DW-1:0] ax_ff, ax_in, ay_ff, ay_in, ca_ff, ca_in;
   logic [DW-1:0] px_ff, px_in, py_ff, py_in;
   logic [DW-1:0] num_ff, num_in, tmp_ff, tmp_in, lam_ff, lam_in;
   logic [DW-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [DW-1:0] iq_ff, iq_in, mod_ff, mod_in;
   logic [DW-1:0] rr_ff, rr_in, kinv_ff, kinv_in, hres_ff, hres_in, hbase_ff, hbase_in;
   logic [GROUP_BITS-1:0] k_ff, k_in, cnt_ff, cnt_in, e_ff, e_in;
   logic pinf_ff, pinf_in, ok_ff, ok_in, wait_ff, wait_in;
   logic v_ff, v_in, f_ff, f_in;
   logic [GROUP_BITS-1:0] ro_ff, ro_in, so_ff, so_in;

   logic [DW-1:0] pw, qw;
   logic          use_alu;
   logic          done_now;
   logic          p_ok, q_ok;

   function automatic logic [DW-1:0] mod_add(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                             input logic [DW-1:0] m);
      logic [DW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m})
         s = s - {1'b0, m};
      return s[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] mod_sub(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                             input logic [DW-1:0] m);
      return (x >= y) ? x - y : x - y + m;
   endfunction

   assign pw       = DW'(field_prime);
   assign qw       = DW'(group_order);
   assign p_ok     = (pw >= DW'(2));
   assign q_ok     = (qw >= DW'(2));
   assign done_now = wait_ff && alu_done;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:
            if (start)
               state_in = (p_ok && nonce != '0) ? S_RED_X : S_LOOP;
         S_RED_X:  if (done_now) state_in = S_RED_Y;
         S_RED_Y:  if (done_now) state_in = S_RED_A;
         S_RED_A:  if (done_now) state_in = S_LOOP;
         S_LOOP: begin
            priority if (cnt_ff == k_ff)
               state_in = !q_ok ? S_IDLE : (pinf_ff ? S_K_MOD : S_R_MOD);
            else if (pinf_ff)
               state_in = S_LOOP;
            else if (px_ff == ax_ff)
               state_in = (py_ff != ay_ff) ? S_LOOP : S_DBL_SQ;
            else
               state_in = S_INV_CHK;
         end
         S_DBL_SQ:  if (done_now) state_in = S_DBL_N1;
         S_DBL_N1:  state_in = S_DBL_N2;
         S_DBL_N2:  state_in = S_DBL_N3;
         S_DBL_N3:  state_in = S_INV_CHK;
         S_INV_CHK: state_in = (r1_ff == '0) ? ret_ff : S_INV_DIV;
         S_INV_DIV: if (done_now) state_in = (alu_res == '0) ? ret_ff : S_INV_MUL;
         S_INV_MUL: if (done_now) state_in = S_INV_DIV;
         S_ADD_LAM: begin
            if (!ok_ff)
               state_in = S_LOOP;
            else if (done_now)
               state_in = S_ADD_X1;
         end
         S_ADD_X1:   if (done_now) state_in = S_ADD_X2;
         S_ADD_X2:   state_in = S_ADD_X3;
         S_ADD_X3:   state_in = S_ADD_Y1;
         S_ADD_Y1:   if (done_now) state_in = S_ADD_Y2;
         S_ADD_Y2:   state_in = S_LOOP;
         S_R_MOD:    if (done_now) state_in = S_K_MOD;
         S_K_MOD:    if (done_now) state_in = S_INV_CHK;
         S_KINV_RET: state_in = S_H_STEP;
         S_H_STEP: begin
            priority if (e_ff == '0)
               state_in = S_KEY_MOD;
            else if (e_ff[0])
               state_in = S_H_MUL;
            else
               state_in = S_H_SQR;
         end
         S_H_MUL:   if (done_now) state_in = S_H_SQR;
         S_H_SQR:   if (done_now) state_in = S_H_STEP;
         S_KEY_MOD: if (done_now) state_in = S_KEY_MUL;
         S_KEY_MUL: if (done_now) state_in = S_S_SUM;
         S_S_SUM:   state_in = S_S_MUL;
         S_S_MUL:   if (done_now) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Datapath and unit control
   always_comb begin
      ret_in = ret_ff;
      ax_in = ax_ff; ay_in = ay_ff; ca_in = ca_ff;
      px_in = px_ff; py_in = py_ff;
      num_in = num_ff; tmp_in = tmp_ff; lam_in = lam_ff;
      r0_in = r0_ff; r1_in = r1_ff; t0_in = t0_ff; t1_in = t1_ff;
      iq_in = iq_ff; mod_in = mod_ff;
      rr_in = rr_ff; kinv_in = kinv_ff; hres_in = hres_ff; hbase_in = hbase_ff;
      k_in = k_ff; cnt_in = cnt_ff; e_in = e_ff;
      pinf_in = pinf_ff; ok_in = ok_ff;
      v_in = 1'b0; f_in = f_ff; ro_in = ro_ff; so_in = so_ff;
      use_alu = 1'b0;
      alu_ctl.op = ALU_DIV;
      alu_a = '0;
      alu_b = '0;
      alu_m = pw;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ax_in = DW'(base_x);
               ay_in = DW'(base_y);
               k_in  = nonce;
               e_in  = message;
               if (p_ok && nonce != '0) begin
                  cnt_in  = GROUP_BITS'(1);
                  pinf_in = 1'b0;
               end else begin
                  cnt_in  = nonce;
                  pinf_in = 1'b1;
               end
            end
         end
         // Reduce the base point and coefficient into the field
         S_RED_X: begin
            use_alu = 1'b1;
            alu_a = ax_ff;
            if (done_now) ax_in = alu_res;
         end
         S_RED_Y: begin
            use_alu = 1'b1;
            alu_a = ay_ff;
            if (done_now) ay_in = alu_res;
         end
         S_RED_A: begin
            use_alu = 1'b1;
            alu_a = DW'(curve_a);
            if (done_now) begin
               ca_in = alu_res;
               px_in = ax_ff;
               py_in = ay_ff;
            end
         end
         // Pick the next point operation or leave for the scalar side (or for idle if q < 2)
         S_LOOP: begin
            priority if (cnt_ff == k_ff) begin
               if (!q_ok) begin
                  v_in  = 1'b1;
                  ro_in = '0;
                  so_in = '0;
                  f_in  = 1'b1;
               end else if (pinf_ff) begin
                  rr_in = '0;
               end
            end else if (pinf_ff) begin
               px_in   = ax_ff;
               py_in   = ay_ff;
               pinf_in = 1'b0;
               cnt_in  = cnt_ff + 1'b1;
            end else if (px_ff == ax_ff) begin
               if (py_ff != ay_ff) begin
                  pinf_in = 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
               end
            end else begin
               num_in = mod_sub(ay_ff, py_ff, pw);
               r0_in  = pw;
               r1_in  = mod_sub(ax_ff, px_ff, pw);
               t0_in  = '0;
               t1_in  = DW'(1);
               mod_in = pw;
               ret_in = S_ADD_LAM;
            end
         end
         // Tangent slope numerator 3x^2 + a
         S_DBL_SQ: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = px_ff;
            alu_b = px_ff;
            if (done_now) tmp_in = alu_res;
         end
         S_DBL_N1: num_in = mod_add(tmp_ff, tmp_ff, pw);
         S_DBL_N2: num_in = mod_add(num_ff, tmp_ff, pw);
         S_DBL_N3: begin
            num_in = mod_add(num_ff, ca_ff, pw);
            r0_in  = pw;
            r1_in  = mod_add(py_ff, py_ff, pw);
            t0_in  = '0;
            t1_in  = DW'(1);
            mod_in = pw;
            ret_in = S_ADD_LAM;
         end
         // Extended Euclid with the cofactor kept reduced
         S_INV_CHK: begin
            if (r1_ff == '0) ok_in = 1'b0;
         end
         S_INV_DIV: begin
            use_alu = 1'b1;
            alu_a = r0_ff;
            alu_m = r1_ff;
            if (done_now) begin
               r0_in = r1_ff;
               r1_in = alu_res;
               iq_in = alu_quo;
               if (alu_res == '0) begin
                  ok_in = (r1_ff == DW'(1));
                  t0_in = t1_ff;
               end
            end
         end
         S_INV_MUL: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = t1_ff;
            alu_b = iq_ff;
            alu_m = mod_ff;
            if (done_now) begin
               t0_in = t1_ff;
               t1_in = mod_sub(t0_ff, alu_res, mod_ff);
            end
         end
         S_ADD_LAM: begin
            if (!ok_ff) begin
               pinf_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               use_alu = 1'b1;
               alu_ctl.op = ALU_MUL;
               alu_a = num_ff;
               alu_b = t0_ff;
               if (done_now) lam_in = alu_res;
            end
         end
         S_ADD_X1: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = lam_ff;
            alu_b = lam_ff;
            if (done_now) tmp_in = alu_res;
         end
         S_ADD_X2: tmp_in = mod_sub(tmp_ff, px_ff, pw);
         S_ADD_X3: tmp_in = mod_sub(tmp_ff, ax_ff, pw);
         S_ADD_Y1: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = lam_ff;
            alu_b = mod_sub(px_ff, tmp_ff, pw);
            if (done_now) num_in = alu_res;
         end
         S_ADD_Y2: begin
            py_in  = mod_sub(num_ff, py_ff, pw);
            px_in  = tmp_ff;
            cnt_in = cnt_ff + 1'b1;
         end
         // Scalar side, all mod q
         S_R_MOD: begin
            use_alu = 1'b1;
            alu_a = px_ff;
            alu_m = qw;
            if (done_now) rr_in = alu_res;
         end
         S_K_MOD: begin
            use_alu = 1'b1;
            alu_a = DW'(k_ff);
            alu_m = qw;
            if (done_now) begin
               r0_in  = qw;
               r1_in  = alu_res;
               t0_in  = '0;
               t1_in  = DW'(1);
               mod_in = qw;
               ret_in = S_KINV_RET;
            end
         end
         S_KINV_RET: begin
            kinv_in  = ok_ff ? t0_ff : '0;
            hres_in  = DW'(1);
            hbase_in = (qw == DW'(2)) ? '0 : DW'(2);
         end
         S_H_STEP: ;
         S_H_MUL: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = hres_ff;
            alu_b = hbase_ff;
            alu_m = qw;
            if (done_now) hres_in = alu_res;
         end
         S_H_SQR: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = hbase_ff;
            alu_b = hbase_ff;
            alu_m = qw;
            if (done_now) begin
               hbase_in = alu_res;
               e_in     = e_ff >> 1;
            end
         end
         S_KEY_MOD: begin
            use_alu = 1'b1;
            alu_a = DW'(private_key);
            alu_m = qw;
            if (done_now) tmp_in = alu_res;
         end
         S_KEY_MUL: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = tmp_ff;
            alu_b = rr_ff;
            alu_m = qw;
            if (done_now) tmp_in = alu_res;
         end
         S_S_SUM: tmp_in = mod_add(hres_ff, tmp_ff, qw);
         S_S_MUL: begin
            use_alu = 1'b1;
            alu_ctl.op = ALU_MUL;
            alu_a = kinv_ff;
            alu_b = tmp_ff;
            alu_m = qw;
            if (done_now) begin
               v_in  = 1'b1;
               ro_in = rr_ff[GROUP_BITS-1:0];
               so_in = alu_res[GROUP_BITS-1:0];
               f_in  = (rr_ff == '0) || (alu_res == '0);
            end
         end
         default: ;
      endcase
      alu_ctl.start = use_alu && !wait_ff;
      wait_in       = use_alu && !done_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
         v_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         v_ff     <= v_in;
      end
      ret_ff <= ret_in;
      ax_ff <= ax_in; ay_ff <= ay_in; ca_ff <= ca_in;
      px_ff <= px_in; py_ff <= py_in;
      num_ff <= num_in; tmp_ff <= tmp_in; lam_ff <= lam_in;
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in;
      iq_ff <= iq_in; mod_ff <= mod_in;
      rr_ff <= rr_in; kinv_ff <= kinv_in; hres_ff <= hres_in; hbase_ff <= hbase_in;
      k_ff <= k_in; cnt_ff <= cnt_in; e_ff <= e_in;
      pinf_ff <= pinf_in; ok_ff <= ok_in;
      f_ff <= f_in; ro_ff <= ro_in; so_ff <= so_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = v_ff;
   assign rsp_sig_r        = ro_ff;
   assign rsp_sig_s        = so_ff;
   assign rsp_retry_needed = f_ff;

endmodule
